>>> hw/rtl/thrs_pkg.sv
// ============================================================================
// thrs_pkg
// Shared types, codes and the CRC-8 helper for the one-wire thermometer
// read sequencer.
// ============================================================================
package thrs_pkg;

    // Input operation codes (replies from the bus engine).
    localparam logic [2:0] OP_START      = 3'd0;
    localparam logic [2:0] OP_RESET_DONE = 3'd1;
    localparam logic [2:0] OP_WRITE_DONE = 3'd2;
    localparam logic [2:0] OP_BIT_REPLY  = 3'd3;
    localparam logic [2:0] OP_BYTE_REPLY = 3'd4;
    localparam logic [2:0] OP_WAIT_DONE  = 3'd5;

    // Commands to the bus engine.
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_RESET = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_RBIT  = 3'd3;
    localparam logic [2:0] CMD_RBYTE = 3'd4;
    localparam logic [2:0] CMD_WAIT  = 3'd5;

    // Final status codes.
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NO_PRES_CONV = 3'd1;
    localparam logic [2:0] ST_TIMEOUT      = 3'd2;
    localparam logic [2:0] ST_NO_PRES_READ = 3'd3;
    localparam logic [2:0] ST_CRC_ERR      = 3'd4;

    // Bus command bytes.
    localparam logic [7:0] ROM_SKIP       = 8'hCC;
    localparam logic [7:0] FN_CONVERT     = 8'h44;
    localparam logic [7:0] FN_READ_SCRPAD = 8'hBE;
    localparam logic [7:0] CRC_POLY       = 8'h8C;

    // Scratchpad layout: eight data bytes followed by the CRC byte.
    localparam logic [3:0] SCRPAD_DATA_BYTES = 4'd8;

    // Reset value of the ready poll limit.
    localparam logic [15:0] POLL_LIMIT_RST = 16'd800;

    // Payload of one input transfer.
    typedef struct packed {
        logic [2:0] op;
        logic       presence;
        logic       bit_in;
        logic [7:0] byte_in;
    } t_in_item;

    // Payload of one result transfer.
    typedef struct packed {
        logic [2:0]         command;
        logic [7:0]         write_data;
        logic               done_res;
        logic [2:0]         status;
        logic signed [15:0] temperature;
    } t_out_item;

    // Reflected CRC-8, one byte, LSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc;
        d = data;
        for (int k = 0; k < 8; k++) begin
            mix = c[0] ^ d[0];
            c   = {1'b0, c[7:1]};
            if (mix) begin
                c = c ^ CRC_POLY;
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/thrs_in_stage.sv
// ============================================================================
// thrs_in_stage
// Input register: captures one transfer and holds it until the result
// register can take the processed item.
// ============================================================================
module thrs_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  thrs_pkg::t_in_item  i_data,
    input  logic                i_advance,
    output logic                o_stall,
    output logic                o_fire,
    output thrs_pkg::t_in_item  o_item
);

    logic               r_valid;
    thrs_pkg::t_in_item r_data;
    logic               accept;

    // The held item moves on whenever the result register advances.
    assign o_fire  = r_valid & i_advance;
    assign o_stall = r_valid & ~i_advance;
    assign accept  = i_valid & ~o_stall;
    assign o_item  = r_data;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_data;
        end
    end

endmodule

>>> hw/rtl/thrs_step.sv
// ============================================================================
// thrs_step
// Sequencer state and the next-step logic: turns one bus reply into one
// command or final result, and holds the poll limit register.
// ============================================================================
module thrs_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  thrs_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    output thrs_pkg::t_out_item o_result
);

    // Sequencer phases.
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_RST1    = 4'd1;
    localparam logic [3:0] PH_SKIP1   = 4'd2;
    localparam logic [3:0] PH_CONV    = 4'd3;
    localparam logic [3:0] PH_POLL    = 4'd4;
    localparam logic [3:0] PH_WAITMS  = 4'd5;
    localparam logic [3:0] PH_RST2    = 4'd6;
    localparam logic [3:0] PH_SKIP2   = 4'd7;
    localparam logic [3:0] PH_RDCMD   = 4'd8;
    localparam logic [3:0] PH_READING = 4'd9;

    logic [15:0] r_poll_limit;
    logic [3:0]  r_phase,      n_phase;
    logic [15:0] r_polls_left, n_polls_left;
    logic [3:0]  r_bytes,      n_bytes;
    logic [7:0]  r_crc,        n_crc;
    logic [7:0]  r_temp_lo,    n_temp_lo;
    logic [7:0]  r_temp_hi,    n_temp_hi;
    logic [15:0] polls_dec;
    thrs_pkg::t_out_item res;

    assign polls_dec = r_polls_left - 16'd1;

    // Next state and result for the item in the input register.
    always_comb begin
        n_phase      = r_phase;
        n_polls_left = r_polls_left;
        n_bytes      = r_bytes;
        n_crc        = r_crc;
        n_temp_lo    = r_temp_lo;
        n_temp_hi    = r_temp_hi;
        res          = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.op == thrs_pkg::OP_START) begin
                    res.command = thrs_pkg::CMD_RESET;
                    n_phase     = PH_RST1;
                end
            end
            PH_RST1: begin
                if (i_item.op == thrs_pkg::OP_RESET_DONE) begin
                    if (i_item.presence) begin
                        res.command    = thrs_pkg::CMD_WRITE;
                        res.write_data = thrs_pkg::ROM_SKIP;
                        n_phase        = PH_SKIP1;
                    end else begin
                        res.done_res = 1'b1;
                        res.status   = thrs_pkg::ST_NO_PRES_CONV;
                        n_phase      = PH_IDLE;
                    end
                end
            end
            PH_SKIP1: begin
                if (i_item.op == thrs_pkg::OP_WRITE_DONE) begin
                    res.command    = thrs_pkg::CMD_WRITE;
                    res.write_data = thrs_pkg::FN_CONVERT;
                    n_phase        = PH_CONV;
                end
            end
            PH_CONV: begin
                if (i_item.op == thrs_pkg::OP_WRITE_DONE) begin
                    n_polls_left = r_poll_limit;
                    if (r_poll_limit == 16'd0) begin
                        res.done_res = 1'b1;
                        res.status   = thrs_pkg::ST_TIMEOUT;
                        n_phase      = PH_IDLE;
                    end else begin
                        res.command = thrs_pkg::CMD_RBIT;
                        n_phase     = PH_POLL;
                    end
                end
            end
            PH_POLL: begin
                if (i_item.op == thrs_pkg::OP_BIT_REPLY) begin
                    if (i_item.bit_in) begin
                        res.command = thrs_pkg::CMD_RESET;
                        n_phase     = PH_RST2;
                    end else begin
                        res.command = thrs_pkg::CMD_WAIT;
                        n_phase     = PH_WAITMS;
                    end
                end
            end
            PH_WAITMS: begin
                if (i_item.op == thrs_pkg::OP_WAIT_DONE) begin
                    n_polls_left = polls_dec;
                    if (polls_dec == 16'd0) begin
                        res.done_res = 1'b1;
                        res.status   = thrs_pkg::ST_TIMEOUT;
                        n_phase      = PH_IDLE;
                    end else begin
                        res.command = thrs_pkg::CMD_RBIT;
                        n_phase     = PH_POLL;
                    end
                end
            end
            PH_RST2: begin
                if (i_item.op == thrs_pkg::OP_RESET_DONE) begin
                    if (i_item.presence) begin
                        res.command    = thrs_pkg::CMD_WRITE;
                        res.write_data = thrs_pkg::ROM_SKIP;
                        n_phase        = PH_SKIP2;
                    end else begin
                        res.done_res = 1'b1;
                        res.status   = thrs_pkg::ST_NO_PRES_READ;
                        n_phase      = PH_IDLE;
                    end
                end
            end
            PH_SKIP2: begin
                if (i_item.op == thrs_pkg::OP_WRITE_DONE) begin
                    res.command    = thrs_pkg::CMD_WRITE;
                    res.write_data = thrs_pkg::FN_READ_SCRPAD;
                    n_phase        = PH_RDCMD;
                end
            end
            PH_RDCMD: begin
                if (i_item.op == thrs_pkg::OP_WRITE_DONE) begin
                    n_bytes     = 4'd0;
                    n_crc       = 8'd0;
                    res.command = thrs_pkg::CMD_RBYTE;
                    n_phase     = PH_READING;
                end
            end
            PH_READING: begin
                if (i_item.op == thrs_pkg::OP_BYTE_REPLY) begin
                    if (r_bytes == 4'd0) begin
                        n_temp_lo = i_item.byte_in;
                    end
                    if (r_bytes == 4'd1) begin
                        n_temp_hi = i_item.byte_in;
                    end
                    if (r_bytes < thrs_pkg::SCRPAD_DATA_BYTES) begin
                        n_crc       = thrs_pkg::crc8_byte(r_crc, i_item.byte_in);
                        n_bytes     = r_bytes + 4'd1;
                        res.command = thrs_pkg::CMD_RBYTE;
                    end else begin
                        // The ninth byte is the device CRC.
                        n_bytes      = 4'd0;
                        res.done_res = 1'b1;
                        n_phase      = PH_IDLE;
                        if (r_crc == i_item.byte_in) begin
                            res.status      = thrs_pkg::ST_OK;
                            res.temperature = $signed({r_temp_hi, r_temp_lo});
                        end else begin
                            res.status = thrs_pkg::ST_CRC_ERR;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign o_result = res;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= thrs_pkg::POLL_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_poll_limit <= i_cfg_wdata;
        end
    end

    // Sequencer state updates when the item moves to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_polls_left <= 16'd0;
            r_bytes      <= 4'd0;
            r_crc        <= 8'd0;
            r_temp_lo    <= 8'd0;
            r_temp_hi    <= 8'd0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_polls_left <= n_polls_left;
            r_bytes      <= n_bytes;
            r_crc        <= n_crc;
            r_temp_lo    <= n_temp_lo;
            r_temp_hi    <= n_temp_hi;
        end
    end

endmodule

>>> hw/rtl/thrs_out_stage.sv
// ============================================================================
// thrs_out_stage
// Result register: holds one result until the receiver takes it.
// ============================================================================
module thrs_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  thrs_pkg::t_out_item i_result,
    input  logic                i_stall,
    output logic                o_advance,
    output logic                o_valid,
    output thrs_pkg::t_out_item o_data
);

    logic                r_valid;
    thrs_pkg::t_out_item r_data;

    // The register can load when empty or when its result is taken now.
    assign o_advance = ~r_valid | ~i_stall;
    assign o_valid   = r_valid;
    assign o_data    = r_data;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_fire;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_data <= i_result;
        end
    end

endmodule

>>> hw/rtl/thermometer_read_sequencer_core.sv
// ============================================================================
// thermometer_read_sequencer_core
// Sequences a skip-ROM thermometer reading with CRC-8 check over a
// byte-level one-wire bus engine.
// ============================================================================
// Usage:
//   Input channel (i_in_valid, i_in_data, o_in_stall) carries bus engine
//   replies and the start request. Each accepted transfer yields exactly
//   one result transfer on the output channel (o_out_valid, o_out_data,
//   i_out_stall): the next bus command, or a final result with status and
//   raw temperature in sixteenths of a degree.
//   An input transfer is held in the input register and moves on to the
//   result register when that register advances; the result register
//   drives o_out_valid. Throughput is one item per cycle while the
//   receiver does not stall; the sequencer state loop closes between the
//   input and result registers: the state updates as the result loads.
//   When the receiver stalls, the result register holds, the input register
//   fills, and o_in_stall rises only once both are occupied. A synchronous
//   active-low reset empties both registers, returns the sequencer to idle
//   and loads the poll limit with 800. The user must write the poll limit
//   via i_cfg_we / i_cfg_wdata only while no reading is active; not enforced.
// ============================================================================
module thermometer_read_sequencer_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  thrs_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output thrs_pkg::t_out_item o_out_data,
    input  logic                i_out_stall,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata
);

    logic                fire;
    logic                advance;
    thrs_pkg::t_in_item  item;
    thrs_pkg::t_out_item result;

    // Input register.
    thrs_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_data    (i_in_data),
        .i_advance (advance),
        .o_stall   (o_in_stall),
        .o_fire    (fire),
        .o_item    (item)
    );

    // Sequencer state and step logic.
    thrs_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (result)
    );

    // Result register.
    thrs_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_result  (result),
        .i_stall   (i_out_stall),
        .o_advance (advance),
        .o_valid   (o_out_valid),
        .o_data    (o_out_data)
    );

endmodule

>>> hw/rtl/thrs_checker.sv
// ============================================================================
// thrs_checker
// Port-level checks for the thermometer read sequencer, bound to the top.
// ============================================================================
module thrs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input thrs_pkg::t_out_item o_out_data,
    input logic                i_out_stall
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result transfer holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // A command and a final result never share one transfer.
    a_cmd_or_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.command != thrs_pkg::CMD_NONE
        |-> !o_out_data.done_res && o_out_data.status == thrs_pkg::ST_OK
            && o_out_data.temperature == 16'sd0)
        else $error("command transfer carries result fields");

    // Write data only accompanies a write command.
    a_wdata_only_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.command != thrs_pkg::CMD_WRITE
        |-> o_out_data.write_data == 8'd0)
        else $error("write data without write command");

    // A failed reading reports zero temperature.
    a_fail_zero_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res && o_out_data.status != thrs_pkg::ST_OK
        |-> o_out_data.temperature == 16'sd0)
        else $error("temperature on failed reading");

endmodule

bind thermometer_read_sequencer_core thrs_checker u_thrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

>>> sim/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the one-wire thermometer read sequencer. Bus
// engine replies are queued as whole readings: good ones, missing presence,
// poll timeouts and CRC errors. Replies that do not fit the current step are
// mixed in. A clocked driver and monitor move transfers with random gaps and
// stalls. Every result is checked against a cycle-free model of the
// sequencer that runs on each accepted reply.
// ============================================================================
module tb_top;

    // Op codes that no step of the sequencer accepts.
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    typedef enum logic [3:0] {
        P_IDLE, P_PRES_CONV, P_SKIP_CONV, P_CONVERT, P_POLL, P_POLL_WAIT,
        P_PRES_READ, P_SKIP_READ, P_READ_CMD, P_READ_BYTES
    } t_seq_phase;

    typedef enum {
        R_OK, R_NO_PRES_CONV, R_TIMEOUT, R_NO_PRES_READ, R_BAD_CRC
    } t_reading_end;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    thrs_pkg::t_in_item  in_data   = '0;
    logic                in_stall;
    logic                out_valid;
    thrs_pkg::t_out_item out_data;
    logic                out_stall = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [15:0]         cfg_wdata = '0;

    // Stimulus and scoreboard storage.
    thrs_pkg::t_in_item  reply_q[$];
    thrs_pkg::t_out_item expected_cmds[$];
    int        replies_outstanding = 0;
    int        replies_generated   = 0;
    int        mismatches          = 0;
    int        idle_pct            = 9;
    int        noise_pct           = 0;
    bit        accept_tog          = 1'b0;
    bit        seen_tog            = 1'b0;

    // Model state of the sequencer.
    t_seq_phase  seq_phase  = P_IDLE;
    logic [15:0] poll_cap   = thrs_pkg::POLL_LIMIT_RST;
    logic [15:0] polls_left = '0;
    logic [3:0]  bytes_seen = '0;
    logic [7:0]  crc_acc    = '0;
    logic [7:0]  temp_lo    = '0;
    logic [7:0]  temp_hi    = '0;

    thermometer_read_sequencer_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Reflected CRC-8, data taken LSB first.
    function automatic logic [7:0] crc8_lsb_first(input logic [7:0] c, input logic [7:0] d);
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ ((c[0] ^ d[i]) ? thrs_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic thrs_pkg::t_out_item reading_done(input logic [2:0] st,
                                                         input logic [15:0] t);
        thrs_pkg::t_out_item o;
        o = '0;
        o.done_res    = 1'b1;
        o.status      = st;
        o.temperature = t;
        return o;
    endfunction

    // Next bus command (or final result) for one accepted reply.
    function automatic thrs_pkg::t_out_item predict_command(input thrs_pkg::t_in_item r);
        thrs_pkg::t_out_item o;
        o = '0;
        case (seq_phase)
            P_IDLE: if (r.op == thrs_pkg::OP_START) begin
                o.command = thrs_pkg::CMD_RESET;
                seq_phase = P_PRES_CONV;
            end
            P_PRES_CONV: if (r.op == thrs_pkg::OP_RESET_DONE) begin
                if (r.presence) begin
                    o.command    = thrs_pkg::CMD_WRITE;
                    o.write_data = thrs_pkg::ROM_SKIP;
                    seq_phase    = P_SKIP_CONV;
                end else begin
                    o = reading_done(thrs_pkg::ST_NO_PRES_CONV, '0);
                end
            end
            P_SKIP_CONV: if (r.op == thrs_pkg::OP_WRITE_DONE) begin
                o.command    = thrs_pkg::CMD_WRITE;
                o.write_data = thrs_pkg::FN_CONVERT;
                seq_phase    = P_CONVERT;
            end
            P_CONVERT: if (r.op == thrs_pkg::OP_WRITE_DONE) begin
                polls_left = poll_cap;
                if (polls_left == '0) begin
                    o = reading_done(thrs_pkg::ST_TIMEOUT, '0);
                end else begin
                    o.command = thrs_pkg::CMD_RBIT;
                    seq_phase = P_POLL;
                end
            end
            P_POLL: if (r.op == thrs_pkg::OP_BIT_REPLY) begin
                o.command = r.bit_in ? thrs_pkg::CMD_RESET : thrs_pkg::CMD_WAIT;
                seq_phase = r.bit_in ? P_PRES_READ : P_POLL_WAIT;
            end
            P_POLL_WAIT: if (r.op == thrs_pkg::OP_WAIT_DONE) begin
                polls_left = polls_left - 16'd1;
                if (polls_left == '0) begin
                    o = reading_done(thrs_pkg::ST_TIMEOUT, '0);
                end else begin
                    o.command = thrs_pkg::CMD_RBIT;
                    seq_phase = P_POLL;
                end
            end
            P_PRES_READ: if (r.op == thrs_pkg::OP_RESET_DONE) begin
                if (r.presence) begin
                    o.command    = thrs_pkg::CMD_WRITE;
                    o.write_data = thrs_pkg::ROM_SKIP;
                    seq_phase    = P_SKIP_READ;
                end else begin
                    o = reading_done(thrs_pkg::ST_NO_PRES_READ, '0);
                end
            end
            P_SKIP_READ: if (r.op == thrs_pkg::OP_WRITE_DONE) begin
                o.command    = thrs_pkg::CMD_WRITE;
                o.write_data = thrs_pkg::FN_READ_SCRPAD;
                seq_phase    = P_READ_CMD;
            end
            P_READ_CMD: if (r.op == thrs_pkg::OP_WRITE_DONE) begin
                bytes_seen = '0;
                crc_acc    = '0;
                o.command  = thrs_pkg::CMD_RBYTE;
                seq_phase  = P_READ_BYTES;
            end
            P_READ_BYTES: if (r.op == thrs_pkg::OP_BYTE_REPLY) begin
                if (bytes_seen == 4'd0) temp_lo = r.byte_in;
                if (bytes_seen == 4'd1) temp_hi = r.byte_in;
                if (bytes_seen < thrs_pkg::SCRPAD_DATA_BYTES) begin
                    crc_acc    = crc8_lsb_first(crc_acc, r.byte_in);
                    bytes_seen = bytes_seen + 4'd1;
                    o.command  = thrs_pkg::CMD_RBYTE;
                end else begin
                    bytes_seen = '0;
                    if (crc_acc == r.byte_in) begin
                        o = reading_done(thrs_pkg::ST_OK, {temp_hi, temp_lo});
                    end else begin
                        o = reading_done(thrs_pkg::ST_CRC_ERR, '0);
                    end
                end
            end
            default: ;
        endcase
        // Every finished reading goes back to idle.
        if (o.done_res) seq_phase = P_IDLE;
        return o;
    endfunction

    function automatic thrs_pkg::t_in_item random_reply();
        thrs_pkg::t_in_item r;
        r.op       = 3'($urandom_range(7));
        r.presence = 1'($urandom_range(1));
        r.bit_in   = 1'($urandom_range(1));
        r.byte_in  = 8'($urandom_range(255));
        return r;
    endfunction

    function automatic void push_raw(input thrs_pkg::t_in_item r);
        reply_q.push_back(r);
        replies_outstanding++;
    endfunction

    // Queue one reply; the field that its op uses gets val, the rest is random.
    // Sometimes a reply that the current step ignores goes ahead of it.
    function automatic void queue_reply(input logic [2:0] op, input logic [7:0] val);
        thrs_pkg::t_in_item r;
        if ($urandom_range(99) < noise_pct) begin
            r = random_reply();
            while (r.op == op) r.op = 3'($urandom_range(7));
            push_raw(r);
        end
        r    = random_reply();
        r.op = op;
        case (op)
            thrs_pkg::OP_RESET_DONE: r.presence = val[0];
            thrs_pkg::OP_BIT_REPLY:  r.bit_in   = val[0];
            thrs_pkg::OP_BYTE_REPLY: r.byte_in  = val;
            default: ;
        endcase
        push_raw(r);
        replies_generated++;
    endfunction

    // Queue the replies of one whole reading that ends as given.
    function automatic void queue_reading(input t_reading_end how, input int zeros,
                                          input logic [15:0] temp);
        logic [7:0] pad [9];
        logic [7:0] crc;
        queue_reply(thrs_pkg::OP_START, 8'd0);
        queue_reply(thrs_pkg::OP_RESET_DONE, {7'd0, how != R_NO_PRES_CONV});
        if (how == R_NO_PRES_CONV) return;
        queue_reply(thrs_pkg::OP_WRITE_DONE, 8'd0);
        queue_reply(thrs_pkg::OP_WRITE_DONE, 8'd0);
        if (how == R_TIMEOUT || poll_cap == '0) begin
            for (int i = 0; i < int'(poll_cap); i++) begin
                queue_reply(thrs_pkg::OP_BIT_REPLY, 8'd0);
                queue_reply(thrs_pkg::OP_WAIT_DONE, 8'd0);
            end
            return;
        end
        // The ready bit must show up before the poll limit is spent.
        if (zeros > int'(poll_cap) - 1) zeros = int'(poll_cap) - 1;
        for (int i = 0; i < zeros; i++) begin
            queue_reply(thrs_pkg::OP_BIT_REPLY, 8'd0);
            queue_reply(thrs_pkg::OP_WAIT_DONE, 8'd0);
        end
        queue_reply(thrs_pkg::OP_BIT_REPLY, 8'd1);
        queue_reply(thrs_pkg::OP_RESET_DONE, {7'd0, how != R_NO_PRES_READ});
        if (how == R_NO_PRES_READ) return;
        queue_reply(thrs_pkg::OP_WRITE_DONE, 8'd0);
        queue_reply(thrs_pkg::OP_WRITE_DONE, 8'd0);
        pad[0] = temp[7:0];
        pad[1] = temp[15:8];
        crc    = '0;
        for (int i = 0; i < 8; i++) begin
            if (i > 1) pad[i] = 8'($urandom_range(255));
            crc = crc8_lsb_first(crc, pad[i]);
        end
        pad[8] = (how == R_BAD_CRC) ? crc ^ 8'($urandom_range(1, 255)) : crc;
        for (int i = 0; i < 9; i++) queue_reply(thrs_pkg::OP_BYTE_REPLY, pad[i]);
    endfunction

    // Wait until every queued reply has been answered.
    task automatic drain();
        while (replies_outstanding != 0 || expected_cmds.size() != 0) @(negedge clk);
    endtask

    task automatic set_poll_limit(input logic [15:0] v);
        drain();
        repeat (3) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        poll_cap   = v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Input side: record each accepted transfer and predict its result.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            expected_cmds.push_back(predict_command(in_data));
            replies_outstanding--;
            accept_tog = ~accept_tog;
        end
    end

    // Input side: present the next reply, with random gaps.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || accept_tog != seen_tog)) begin
            seen_tog = accept_tog;
            if (reply_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                in_data  <= reply_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side: compare each transfer with the oldest expectation.
    always @(posedge clk) begin
        thrs_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_cmds.size() == 0) begin
                $display("%0t: result with nothing expected: expected none, got %h",
                         $time, out_data);
                mismatches++;
            end else begin
                want = expected_cmds.pop_front();
                check_field("command", 16'(want.command), 16'(out_data.command));
                check_field("write_data", 16'(want.write_data), 16'(out_data.write_data));
                check_field("done_res", 16'(want.done_res), 16'(out_data.done_res));
                check_field("status", 16'(want.status), 16'(out_data.status));
                check_field("temperature", want.temperature, out_data.temperature);
            end
        end
    end

    // Result side: random stalls.
    always @(negedge clk) begin
        out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
    end

    // Test sequence.
    initial begin
        logic [15:0]  limits [7];
        t_reading_end how;
        logic [15:0]  temp;
        int           target;
        limits = '{16'd1, 16'd3, 16'hFFFF, 16'd2, 16'($urandom_range(4, 12)), 16'd800, 16'd5};

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with the reset poll limit: ignored ops in idle, a
        // repeated start, no presence at convert, and a full reading of the
        // most negative temperature.
        queue_reply(OP_UNUSED_6, 8'd0);
        queue_reply(OP_UNUSED_7, 8'd0);
        queue_reply(thrs_pkg::OP_START, 8'd0);
        queue_reply(thrs_pkg::OP_START, 8'd0);
        queue_reply(thrs_pkg::OP_RESET_DONE, 8'd0);
        queue_reading(R_OK, 1, 16'h8000);

        // A zero poll limit times out as soon as conversion starts.
        set_poll_limit(16'd0);
        queue_reading(R_OK, 0, 16'h1234);

        // Random readings under several poll limits; one phase without gaps.
        noise_pct = 6;
        target    = replies_generated;
        for (int p = 0; p < 7; p++) begin
            set_poll_limit(limits[p]);
            idle_pct = (limits[p] == 16'hFFFF) ? 0 : 9;
            target  += 90;
            while (replies_generated < target) begin
                case ($urandom_range(19))
                    0, 1:    how = R_NO_PRES_CONV;
                    2, 3:    how = R_TIMEOUT;
                    4, 5:    how = R_NO_PRES_READ;
                    6, 7:    how = R_BAD_CRC;
                    default: how = R_OK;
                endcase
                if (how == R_TIMEOUT && poll_cap > 16'd50) how = R_OK;
                case ($urandom_range(9))
                    0:       temp = 16'h8000;
                    1:       temp = 16'h7FFF;
                    2:       temp = 16'h0000;
                    3:       temp = 16'hFFFF;
                    default: temp = 16'($urandom_range(16'hFFFF));
                endcase
                queue_reading(how, $urandom_range(3), temp);
            end
        end

        // Closing burst of unstructured replies.
        for (int i = 0; i < 80; i++) push_raw(random_reply());

        drain();
        repeat (10) @(negedge clk);
        if (mismatches == 0) begin
            $display("thermometer_read_sequencer_core test passed");
        end else begin
            $display("thermometer_read_sequencer_core test failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("thermometer_read_sequencer_core test failed");
        $finish;
    end

endmodule
